// ===== rtl/core/preferential_attachment_edge_gen_core_assert.svh =====
`ifndef PREFERENTIAL_ATTACHMENT_EDGE_GEN_CORE_ASSERT_SVH
`define PREFERENTIAL_ATTACHMENT_EDGE_GEN_CORE_ASSERT_SVH

// same-cycle implication, masked while in reset
`define PAEG_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("paeg check failed");

// next-cycle implication, masked while in reset
`define PAEG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("paeg check failed");

`endif

// ===== rtl/core/paeg_pkg.sv =====
package paeg_pkg;

  // field widths
  localparam int DRAW_W     = 10;
  localparam int VTX_OUT_W  = 10;
  localparam int VERTEX_W   = 11;
  localparam int DRAWS_W    = 5;
  localparam int DEG_W      = 16;
  localparam int TOTAL_W    = 21;

  // shared multiplier operands and accumulators
  localparam int PROD_A_W   = 21;
  localparam int PROD_B_W   = 16;
  localparam int PROD_W     = PROD_A_W + PROD_B_W;
  localparam int LHS_W      = TOTAL_W + DRAW_W;
  localparam int RHS_W      = 40;

  localparam logic [DEG_W-1:0]   DEG_MAX   = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // default sizing
  localparam int DEF_MAX_VERTICES = 1024;
  localparam int DEF_MAX_DRAWS    = 16;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_VERTICES     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGES_PER_VERTEX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED_CLIQUE_SIZE = 2'd2;

  localparam logic [VERTEX_W-1:0] RST_NUM_VERTICES     = 11'd1024;
  localparam logic [DRAWS_W-1:0]  RST_EDGES_PER_VERTEX = 5'd2;
  localparam logic [VERTEX_W-1:0] RST_SEED_CLIQUE_SIZE = 11'd10;

endpackage

// ===== rtl/core/paeg_ifs.sv =====
interface paeg_cfg_if import paeg_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

interface paeg_draw_if import paeg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DRAW_W-1:0] random_draw;
  modport source (output valid, random_draw, input ready);
  modport sink (input valid, random_draw, output ready);
endinterface

interface paeg_edge_if import paeg_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [VTX_OUT_W-1:0] source_vertex;
  logic [VTX_OUT_W-1:0] target_vertex;
  logic                 edge_made;
  logic                 finished;
  modport source (output valid, source_vertex, target_vertex, edge_made, finished,
                  input ready);
  modport sink (input valid, source_vertex, target_vertex, edge_made, finished,
                output ready);
endinterface

// ===== rtl/core/paeg_deg_ram.sv =====
module paeg_deg_ram import paeg_pkg::*; #(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
  input  logic                            clk_i,
  input  logic                            we_i,
  input  logic [$clog2(MAX_VERTICES)-1:0] waddr_i,
  input  logic [DEG_W-1:0]                wdata_i,
  input  logic [$clog2(MAX_VERTICES)-1:0] raddr_i,
  output logic [DEG_W-1:0]                rdata_o
);

  logic [DEG_W-1:0] mem [MAX_VERTICES];
  logic [DEG_W-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/paeg_mul.sv =====
module paeg_mul import paeg_pkg::*; (
  input  logic                clk_i,
  input  logic [PROD_A_W-1:0] a_i,
  input  logic [PROD_B_W-1:0] b_i,
  output logic [PROD_W-1:0]   p_o
);

  logic [PROD_W-1:0] p_q;

  // registered product, one result per cycle
  always_ff @(posedge clk_i) begin
    p_q <= PROD_W'(a_i) * PROD_W'(b_i);
  end

  assign p_o = p_q;

endmodule

// ===== rtl/core/preferential_attachment_edge_gen_core.sv =====
// one request in, one result out; the block is busy until the result is registered
// clique edge: both endpoints bumped; attach draw for vertex i: degrees 0 to i - 1 walked,
// first summed on the first draw of a vertex; each picked target bumped when the vertex closes
// the single read port of the degree memory sets the pace: one stored degree per cycle
// after reset the degree memory is swept to zero, and no request is taken until that is done
`include "preferential_attachment_edge_gen_core_assert.svh"

module preferential_attachment_edge_gen_core import paeg_pkg::*; #(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int MAX_DRAWS    = DEF_MAX_DRAWS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  paeg_cfg_if.sink    cfg_i,
  paeg_draw_if.sink   draw_i,
  paeg_edge_if.source edge_o
);

  localparam int AddrW = $clog2(MAX_VERTICES);
  localparam int PendW = (MAX_DRAWS > 1) ? $clog2(MAX_DRAWS) : 1;
  localparam logic [31:0] MaxV = 32'(MAX_VERTICES);
  localparam logic [31:0] MaxD = 32'(MAX_DRAWS);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(MAX_VERTICES - 1);

  typedef enum logic [1:0] {
    PH_CLIQUE,
    PH_ATTACH,
    PH_DONE
  } phase_e;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_SET_A,
    S_SET_B,
    S_SET_END,
    S_CL_RD,
    S_CL_CHK,
    S_CL_NEXT,
    S_CL_END,
    S_BUMP_RD,
    S_BUMP_WR,
    S_CLQ_A,
    S_CLQ_B,
    S_CLQ_END,
    S_ATT,
    S_TOT,
    S_LHS,
    S_LHS_CAP,
    S_WALK,
    S_ATT_END,
    S_OUT
  } state_e;

  // sequencer and walk state
  state_e                state_q, state_d;
  state_e                ret_q, ret_d;
  phase_e                phase_q, phase_d;
  logic                  post_q, post_d;
  logic [VERTEX_W-1:0]   cv_q, cv_d;
  logic [VERTEX_W-1:0]   partner_q, partner_d;
  logic [DRAWS_W-1:0]    di_q, di_d;
  logic [DRAWS_W-1:0]    j_q, j_d;
  logic [TOTAL_W-1:0]    total_q, total_d;
  logic [DRAW_W-1:0]     d_q, d_d;
  logic [LHS_W-1:0]      lhs_q, lhs_d;
  logic [RHS_W-1:0]      rhs_q, rhs_d;
  logic [VERTEX_W-1:0]   ra_q, ra_d;
  logic                  rv_q, rv_d;
  logic [VERTEX_W-1:0]   rk_q, rk_d;
  logic                  pv_q, pv_d;
  logic [VERTEX_W-1:0]   pk_q, pk_d;
  logic [AddrW-1:0]      bump_addr_q, bump_addr_d;
  logic [AddrW-1:0]      clr_q, clr_d;

  // result being built, and the output register
  logic [VTX_OUT_W-1:0]  res_src_q, res_src_d;
  logic [VTX_OUT_W-1:0]  res_dst_q, res_dst_d;
  logic                  res_made_q, res_made_d;
  logic                  ov_q, ov_d;
  logic [VTX_OUT_W-1:0]  out_src_q, out_src_d;
  logic [VTX_OUT_W-1:0]  out_dst_q, out_dst_d;
  logic                  out_made_q, out_made_d;
  logic                  out_fin_q, out_fin_d;

  // configuration registers
  logic [VERTEX_W-1:0]   cfg_n_q;
  logic [DRAWS_W-1:0]    cfg_m_q;
  logic [VERTEX_W-1:0]   cfg_m0_q;

  // effective configuration after clamping to the build limits
  logic [VERTEX_W-1:0]   eff_n;
  logic [DRAWS_W-1:0]    eff_m;
  logic [VERTEX_W-1:0]   eff_m0;
  logic [VERTEX_W-1:0]   nm1;

  // degree memory port
  logic                  ram_we;
  logic [AddrW-1:0]      ram_waddr;
  logic [DEG_W-1:0]      ram_wdata;
  logic [AddrW-1:0]      ram_raddr;
  logic [DEG_W-1:0]      ram_rdata;
  logic [DEG_W-1:0]      deg_inc;

  // shared multiplier
  logic                  mul_sel;
  logic [PROD_A_W-1:0]   mul_a;
  logic [PROD_B_W-1:0]   mul_b;
  logic [PROD_W-1:0]     prod;

  // pending targets of the vertex being attached: flag plus target
  logic [AddrW:0]        pend_mem [MAX_DRAWS];
  logic [AddrW:0]        pend_rd_q;
  logic                  pend_we;
  logic [AddrW:0]        pend_wdata;

  logic [VERTEX_W:0]     cv_inc;
  logic [VERTEX_W:0]     cv_inc2;
  logic [TOTAL_W:0]      tot_sum;
  logic [RHS_W-1:0]      rhs_new;
  logic                  hit;
  logic                  walk_end;

  // -------------------------------------------------------------------------
  // configuration port, always ready
  // -------------------------------------------------------------------------
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_n_q  <= RST_NUM_VERTICES;
      cfg_m_q  <= RST_EDGES_PER_VERTEX;
      cfg_m0_q <= RST_SEED_CLIQUE_SIZE;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_NUM_VERTICES:     cfg_n_q  <= VERTEX_W'(cfg_i.data);
        CFG_EDGES_PER_VERTEX: cfg_m_q  <= DRAWS_W'(cfg_i.data);
        CFG_SEED_CLIQUE_SIZE: cfg_m0_q <= VERTEX_W'(cfg_i.data);
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  assign eff_n  = (32'(cfg_n_q) > MaxV) ? VERTEX_W'(MaxV) : cfg_n_q;
  assign eff_m  = (32'(cfg_m_q) > MaxD) ? DRAWS_W'(MaxD) : cfg_m_q;
  assign eff_m0 = (cfg_m0_q > eff_n) ? eff_n : cfg_m0_q;
  // only used while attaching, where n is at least one
  assign nm1    = eff_n - VERTEX_W'(1);

  // -------------------------------------------------------------------------
  // datapath pieces
  // -------------------------------------------------------------------------
  paeg_deg_ram #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_deg_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // lhs mode: total * draw, once per draw; walk mode: degree * (n - 1), once per vertex
  assign mul_a = mul_sel ? total_q : PROD_A_W'(nm1);
  assign mul_b = mul_sel ? PROD_B_W'(d_q) : ram_rdata;

  paeg_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  assign deg_inc  = (ram_rdata == DEG_MAX) ? ram_rdata : ram_rdata + DEG_W'(1);
  assign cv_inc   = {1'b0, cv_q} + (VERTEX_W+1)'(1);
  assign cv_inc2  = {1'b0, cv_q} + (VERTEX_W+1)'(2);
  assign tot_sum  = {1'b0, total_q} + (TOTAL_W+1)'(ram_rdata);
  // running sum times (n - 1), grown by one product per stored degree
  assign rhs_new  = rhs_q + RHS_W'(prod);
  // first vertex where draw * total < run * (n - 1)
  assign hit      = pv_q && (RHS_W'(lhs_q) < rhs_new);
  assign walk_end = (ra_q >= cv_q) && !rv_q && !pv_q;

  // pending target store: written once per draw, read back when the vertex closes
  always_ff @(posedge clk_i) begin
    if (pend_we) begin
      pend_mem[PendW'(di_q)] <= pend_wdata;
    end
    pend_rd_q <= pend_mem[PendW'(j_q)];
  end

  // -------------------------------------------------------------------------
  // sequencer
  // -------------------------------------------------------------------------
  assign draw_i.ready = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    ret_d       = ret_q;
    phase_d     = phase_q;
    post_d      = post_q;
    cv_d        = cv_q;
    partner_d   = partner_q;
    di_d        = di_q;
    j_d         = j_q;
    total_d     = total_q;
    d_d         = d_q;
    lhs_d       = lhs_q;
    rhs_d       = rhs_q;
    ra_d        = ra_q;
    rv_d        = rv_q;
    rk_d        = rk_q;
    pv_d        = pv_q;
    pk_d        = pk_q;
    bump_addr_d = bump_addr_q;
    clr_d       = clr_q;
    res_src_d   = res_src_q;
    res_dst_d   = res_dst_q;
    res_made_d  = res_made_q;
    ov_d        = ov_q;
    out_src_d   = out_src_q;
    out_dst_d   = out_dst_q;
    out_made_d  = out_made_q;
    out_fin_d   = out_fin_q;
    ram_we      = 1'b0;
    ram_waddr   = bump_addr_q;
    ram_wdata   = deg_inc;
    ram_raddr   = AddrW'(ra_q);
    mul_sel     = 1'b0;
    pend_we     = 1'b0;
    pend_wdata  = '0;

    // result taken downstream
    if (edge_o.valid && edge_o.ready) begin
      ov_d = 1'b0;
    end

    case (state_q)
      // zero the degree memory, one entry per cycle
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + AddrW'(1);
        if (clr_q == LastAddr) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (draw_i.valid) begin
          d_d     = draw_i.random_draw;
          post_d  = 1'b0;
          state_d = S_SET_A;
        end
      end

      // settle, first half: step past a finished clique row, or leave the clique
      S_SET_A: begin
        if (phase_q == PH_CLIQUE && partner_q >= eff_m0) begin
          partner_d = VERTEX_W'(cv_inc2);
          if (cv_inc2 >= {1'b0, eff_m0}) begin
            phase_d = PH_ATTACH;
            cv_d    = eff_m0;
            di_d    = '0;
          end else begin
            cv_d = VERTEX_W'(cv_inc);
          end
        end
        state_d = S_SET_B;
      end

      // settle, second half: finish, or close a vertex whose draws are all made
      S_SET_B: begin
        state_d = S_SET_END;
        if (phase_q == PH_ATTACH) begin
          if (eff_m == '0 || cv_q >= eff_n) begin
            phase_d = PH_DONE;
          end else if (di_q >= eff_m) begin
            j_d     = '0;
            state_d = S_CL_RD;
          end
        end
      end

      // close: walk the pending entries and bump each picked target
      S_CL_RD: begin
        state_d = S_CL_CHK;
      end

      S_CL_CHK: begin
        j_d = j_q + DRAWS_W'(1);
        if (pend_rd_q[AddrW]) begin
          bump_addr_d = pend_rd_q[AddrW-1:0];
          ret_d       = S_CL_NEXT;
          state_d     = S_BUMP_RD;
        end else begin
          state_d = S_CL_NEXT;
        end
      end

      S_CL_NEXT: begin
        state_d = (j_q == di_q) ? S_CL_END : S_CL_RD;
      end

      S_CL_END: begin
        di_d    = '0;
        cv_d    = VERTEX_W'(cv_inc);
        if (cv_inc >= {1'b0, eff_n}) begin
          phase_d = PH_DONE;
        end
        state_d = S_SET_END;
      end

      // settle done: either start the step or hand the result out
      S_SET_END: begin
        if (post_q) begin
          state_d = S_OUT;
        end else begin
          case (phase_q)
            PH_CLIQUE: state_d = S_CLQ_A;
            PH_ATTACH: state_d = S_ATT;
            default: begin
              // finished: empty result
              res_src_d  = '0;
              res_dst_d  = '0;
              res_made_d = 1'b0;
              post_d     = 1'b1;
              state_d    = S_SET_A;
            end
          endcase
        end
      end

      // saturating read-modify-write of one degree
      S_BUMP_RD: begin
        ram_raddr = bump_addr_q;
        state_d   = S_BUMP_WR;
      end

      S_BUMP_WR: begin
        ram_we  = 1'b1;
        state_d = ret_q;
      end

      // clique edge: both endpoints gain a degree
      S_CLQ_A: begin
        res_src_d   = VTX_OUT_W'(cv_q);
        res_dst_d   = VTX_OUT_W'(partner_q);
        res_made_d  = 1'b1;
        bump_addr_d = AddrW'(cv_q);
        ret_d       = S_CLQ_B;
        state_d     = S_BUMP_RD;
      end

      S_CLQ_B: begin
        bump_addr_d = AddrW'(partner_q);
        ret_d       = S_CLQ_END;
        state_d     = S_BUMP_RD;
      end

      S_CLQ_END: begin
        partner_d = partner_q + VERTEX_W'(1);
        post_d    = 1'b1;
        state_d   = S_SET_A;
      end

      // attach draw: clamp the draw, and on the first draw sum the earlier degrees
      S_ATT: begin
        res_src_d  = VTX_OUT_W'(cv_q);
        res_dst_d  = '0;
        res_made_d = 1'b0;
        if ({1'b0, d_q} > nm1) begin
          d_d = DRAW_W'(nm1);
        end
        if (di_q == '0) begin
          ra_d    = '0;
          rv_d    = 1'b0;
          total_d = '0;
          state_d = S_TOT;
        end else begin
          state_d = S_LHS;
        end
      end

      S_TOT: begin
        if (ra_q < cv_q) begin
          ra_d = ra_q + VERTEX_W'(1);
          rv_d = 1'b1;
        end else begin
          rv_d = 1'b0;
        end
        if (rv_q) begin
          total_d = tot_sum[TOTAL_W] ? TOTAL_MAX : tot_sum[TOTAL_W-1:0];
        end
        if (ra_q >= cv_q && !rv_q) begin
          state_d = S_LHS;
        end
      end

      S_LHS: begin
        mul_sel = 1'b1;
        state_d = S_LHS_CAP;
      end

      S_LHS_CAP: begin
        lhs_d   = LHS_W'(prod);
        rhs_d   = '0;
        ra_d    = '0;
        rv_d    = 1'b0;
        pv_d    = 1'b0;
        state_d = S_WALK;
      end

      // walk: read, multiply, accumulate and compare, one degree per cycle
      S_WALK: begin
        if (ra_q < cv_q) begin
          ra_d = ra_q + VERTEX_W'(1);
          rv_d = 1'b1;
          rk_d = ra_q;
        end else begin
          rv_d = 1'b0;
        end
        pv_d = rv_q;
        pk_d = rk_q;
        if (pv_q) begin
          rhs_d = rhs_new;
        end
        if (hit) begin
          res_dst_d   = VTX_OUT_W'(pk_q);
          res_made_d  = 1'b1;
          pend_we     = 1'b1;
          pend_wdata  = {1'b1, AddrW'(pk_q)};
          bump_addr_d = AddrW'(cv_q);
          ret_d       = S_ATT_END;
          state_d     = S_BUMP_RD;
        end else if (walk_end) begin
          // no target picked for this draw
          pend_we    = 1'b1;
          pend_wdata = '0;
          state_d    = S_ATT_END;
        end
      end

      S_ATT_END: begin
        di_d    = di_q + DRAWS_W'(1);
        post_d  = 1'b1;
        state_d = S_SET_A;
      end

      // load the output register once it is free
      S_OUT: begin
        if (!ov_q || edge_o.ready) begin
          ov_d       = 1'b1;
          out_src_d  = res_src_q;
          out_dst_d  = res_dst_q;
          out_made_d = res_made_q;
          out_fin_d  = (phase_q == PH_DONE);
          state_d    = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      ret_q       <= S_IDLE;
      phase_q     <= PH_CLIQUE;
      post_q      <= 1'b0;
      cv_q        <= '0;
      partner_q   <= VERTEX_W'(1);
      di_q        <= '0;
      j_q         <= '0;
      total_q     <= '0;
      d_q         <= '0;
      lhs_q       <= '0;
      rhs_q       <= '0;
      ra_q        <= '0;
      rv_q        <= 1'b0;
      rk_q        <= '0;
      pv_q        <= 1'b0;
      pk_q        <= '0;
      bump_addr_q <= '0;
      clr_q       <= '0;
      res_src_q   <= '0;
      res_dst_q   <= '0;
      res_made_q  <= 1'b0;
      ov_q        <= 1'b0;
      out_src_q   <= '0;
      out_dst_q   <= '0;
      out_made_q  <= 1'b0;
      out_fin_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      phase_q     <= phase_d;
      post_q      <= post_d;
      cv_q        <= cv_d;
      partner_q   <= partner_d;
      di_q        <= di_d;
      j_q         <= j_d;
      total_q     <= total_d;
      d_q         <= d_d;
      lhs_q       <= lhs_d;
      rhs_q       <= rhs_d;
      ra_q        <= ra_d;
      rv_q        <= rv_d;
      rk_q        <= rk_d;
      pv_q        <= pv_d;
      pk_q        <= pk_d;
      bump_addr_q <= bump_addr_d;
      clr_q       <= clr_d;
      res_src_q   <= res_src_d;
      res_dst_q   <= res_dst_d;
      res_made_q  <= res_made_d;
      ov_q        <= ov_d;
      out_src_q   <= out_src_d;
      out_dst_q   <= out_dst_d;
      out_made_q  <= out_made_d;
      out_fin_q   <= out_fin_d;
    end
  end

  assign edge_o.valid         = ov_q;
  assign edge_o.source_vertex = out_src_q;
  assign edge_o.target_vertex = out_dst_q;
  assign edge_o.edge_made     = out_made_q;
  assign edge_o.finished      = out_fin_q;

  // -------------------------------------------------------------------------
  // checks
  // -------------------------------------------------------------------------
  // once finished, the block never leaves that phase until reset
  `PAEG_ASSERT_NEXT(a_done_sticky, phase_q == PH_DONE, phase_q == PH_DONE)
  // a pick needs a nonzero degree total for the vertex
  `PAEG_ASSERT_IMPLY(a_pick_total, state_q == S_WALK && hit, total_q != '0)
  // the output register fills only from the output state
  `PAEG_ASSERT_NEXT(a_out_load, state_q != S_OUT && !ov_q, !ov_q)
  // the close walk reads only entries written for this vertex
  `PAEG_ASSERT_IMPLY(a_close_range, state_q == S_CL_CHK, j_q < di_q)

endmodule
